[design/r2y_pkg.sv]
// ----------------------------------------------------------------------------
// r2y_pkg: shared types and constants of the RGB to YCbCr pixel unit
// Beat formats on both ports, inter-stage beats and fixed-point coefficients.
// ----------------------------------------------------------------------------
package r2y_pkg;

  // Input beat: one RGB pixel.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_in_t;

  // Output beat: one YCbCr pixel.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pixel_out_t;

  // Luma segment to difference segment.
  typedef struct packed {
    logic       full_range;
    logic [7:0] blue;
    logic [7:0] red;
    logic [7:0] luma;
  } luma_beat_t;

  // Difference segment to chroma scale segment.
  typedef struct packed {
    logic              full_range;
    logic [7:0]        luma;
    logic signed [13:0] diff_blue;
    logic signed [13:0] diff_red;
  } diff_beat_t;

  // Register map
  localparam int unsigned RegFullRangeMode = 0;

  // Studio range (16-235) coefficients, 16.16 fixed point
  localparam logic [15:0] StuCoefR      = 16'd16829;
  localparam logic [15:0] StuCoefG      = 16'd33039;
  localparam logic [15:0] StuCoefB      = 16'd6416;
  localparam logic [25:0] StuLumaRound  = 26'h108000;
  localparam logic [16:0] StuLumaScale  = 17'd76309;
  localparam logic [15:0] StuKBlue      = 16'd16244;
  localparam logic [15:0] StuKRed       = 16'd20531;
  localparam logic [31:0] StuChromRound = 32'h8080000;
  localparam logic [8:0]  StuLumaOffset = 9'd16;

  // Full range coefficients, 16.16 fixed point
  localparam logic [15:0] FulCoefR      = 16'd19595;
  localparam logic [15:0] FulCoefG      = 16'd38470;
  localparam logic [15:0] FulCoefB      = 16'd7471;
  localparam logic [25:0] FulLumaRound  = 26'h8000;
  localparam logic [15:0] FulKBlue      = 16'd36984;
  localparam logic [15:0] FulKRed       = 16'd46745;
  localparam logic [31:0] FulChromRound = 32'h808000;

endpackage

[design/r2y_luma.sv]
// ----------------------------------------------------------------------------
// r2y_luma: weighted luma sum, two register stages
// Stage one forms the three weighted products, stage two sums and rounds.
// ----------------------------------------------------------------------------
module r2y_luma (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  r2y_pkg::pixel_in_t    pix_i,
  input  logic                  full_range_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output r2y_pkg::luma_beat_t   beat_o
);

  logic        v0_q, v1_q;
  logic        en0, en1;
  logic [23:0] prod_r_d, prod_g_d, prod_b_d;
  logic [23:0] prod_r_q, prod_g_q, prod_b_q;
  logic        mode0_q;
  logic [7:0]  blue0_q, red0_q;
  logic [25:0] sum_d;
  r2y_pkg::luma_beat_t beat_d, beat_q;

  // Advance a stage when it is empty or its successor moves.
  assign en1     = !v1_q || !stall_i;
  assign en0     = !v0_q || en1;
  assign stall_o = !en0;

  always_comb begin
    if (full_range_i) begin
      prod_r_d = 24'(pix_i.red)   * 24'(r2y_pkg::FulCoefR);
      prod_g_d = 24'(pix_i.green) * 24'(r2y_pkg::FulCoefG);
      prod_b_d = 24'(pix_i.blue)  * 24'(r2y_pkg::FulCoefB);
    end else begin
      prod_r_d = 24'(pix_i.red)   * 24'(r2y_pkg::StuCoefR);
      prod_g_d = 24'(pix_i.green) * 24'(r2y_pkg::StuCoefG);
      prod_b_d = 24'(pix_i.blue)  * 24'(r2y_pkg::StuCoefB);
    end
  end

  always_comb begin
    sum_d = 26'(prod_r_q) + 26'(prod_g_q) + 26'(prod_b_q) +
            (mode0_q ? r2y_pkg::FulLumaRound : r2y_pkg::StuLumaRound);
    beat_d.full_range = mode0_q;
    beat_d.blue       = blue0_q;
    beat_d.red        = red0_q;
    // The sum stays below 2^24 in both modes.
    beat_d.luma       = sum_d[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && valid_i) begin
      prod_r_q <= prod_r_d;
      prod_g_q <= prod_g_d;
      prod_b_q <= prod_b_d;
      mode0_q  <= full_range_i;
      blue0_q  <= pix_i.blue;
      red0_q   <= pix_i.red;
    end
    if (en1 && v0_q) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = v1_q;
  assign beat_o  = beat_q;

endmodule

[design/r2y_diff.sv]
// ----------------------------------------------------------------------------
// r2y_diff: colour differences, two register stages
// Studio range rescales luma to full range and scales the difference down by
// 2^11; full range takes the plain difference against luma.
// ----------------------------------------------------------------------------
module r2y_diff (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  r2y_pkg::luma_beat_t   beat_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output r2y_pkg::diff_beat_t   beat_o
);

  logic               v0_q, v1_q;
  logic               en0, en1;
  logic signed [8:0]  luma_off;
  logic signed [26:0] scaled_d, scaled_q;
  r2y_pkg::luma_beat_t lb_q;
  logic signed [26:0] by, ry;
  logic [9:0]         fb, fr;
  r2y_pkg::diff_beat_t beat_d, beat_q;

  assign en1     = !v1_q || !stall_i;
  assign en0     = !v0_q || en1;
  assign stall_o = !en0;

  // Luma rescaled back to full range, in 16.16.
  always_comb begin
    luma_off = $signed({1'b0, beat_i.luma}) - $signed(r2y_pkg::StuLumaOffset);
    scaled_d = 27'(luma_off * $signed({1'b0, r2y_pkg::StuLumaScale}));
  end

  always_comb begin
    by = $signed({3'b000, lb_q.blue, 16'h0000}) - scaled_q;
    ry = $signed({3'b000, lb_q.red,  16'h0000}) - scaled_q;
    fb = {2'b00, lb_q.blue} - {2'b00, lb_q.luma};
    fr = {2'b00, lb_q.red}  - {2'b00, lb_q.luma};
    beat_d.full_range = lb_q.full_range;
    beat_d.luma       = lb_q.luma;
    if (lb_q.full_range) begin
      beat_d.diff_blue = $signed({{4{fb[9]}}, fb});
      beat_d.diff_red  = $signed({{4{fr[9]}}, fr});
    end else begin
      // Arithmetic shift by 11; the result fits 14 signed bits.
      beat_d.diff_blue = by[24:11];
      beat_d.diff_red  = ry[24:11];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && valid_i) begin
      scaled_q <= scaled_d;
      lb_q     <= beat_i;
    end
    if (en1 && v0_q) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = v1_q;
  assign beat_o  = beat_q;

endmodule

[design/r2y_scale.sv]
// ----------------------------------------------------------------------------
// r2y_scale: chroma scaling and output register, two register stages
// Multiply each difference by its chroma factor with rounding, then take the
// byte after the mode's shift.
// ----------------------------------------------------------------------------
module r2y_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  r2y_pkg::diff_beat_t   beat_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output r2y_pkg::pixel_out_t   pix_o
);

  logic               v0_q, v1_q;
  logic               en0, en1;
  logic signed [16:0] k_blue, k_red;
  logic signed [30:0] m_blue, m_red;
  logic [31:0]        rnd;
  logic [31:0]        acc_b_d, acc_r_d, acc_b_q, acc_r_q;
  logic               mode_q;
  logic [7:0]         luma_q;
  r2y_pkg::pixel_out_t pix_d, pix_q;

  assign en1     = !v1_q || !stall_i;
  assign en0     = !v0_q || en1;
  assign stall_o = !en0;

  always_comb begin
    if (beat_i.full_range) begin
      k_blue = $signed({1'b0, r2y_pkg::FulKBlue});
      k_red  = $signed({1'b0, r2y_pkg::FulKRed});
      rnd    = r2y_pkg::FulChromRound;
    end else begin
      k_blue = $signed({1'b0, r2y_pkg::StuKBlue});
      k_red  = $signed({1'b0, r2y_pkg::StuKRed});
      rnd    = r2y_pkg::StuChromRound;
    end
    m_blue  = 31'(beat_i.diff_blue * k_blue);
    m_red   = 31'(beat_i.diff_red  * k_red);
    acc_b_d = {m_blue[30], m_blue} + rnd;
    acc_r_d = {m_red[30],  m_red}  + rnd;
  end

  // Low byte of the arithmetic shift: 16 for full range, 20 for studio.
  always_comb begin
    pix_d.luma = luma_q;
    if (mode_q) begin
      pix_d.chroma_blue = acc_b_q[23:16];
      pix_d.chroma_red  = acc_r_q[23:16];
    end else begin
      pix_d.chroma_blue = acc_b_q[27:20];
      pix_d.chroma_red  = acc_r_q[27:20];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && valid_i) begin
      acc_b_q <= acc_b_d;
      acc_r_q <= acc_r_d;
      mode_q  <= beat_i.full_range;
      luma_q  <= beat_i.luma;
    end
    if (en1 && v0_q) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = v1_q;
  assign pix_o   = pix_q;

endmodule

[design/rgb_to_ycbcr_pixel_unit.sv]
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_pixel_unit: BT.601 RGB to YCbCr pixel converter
// Six-stage pipeline with an APB register for the range mode.
// ----------------------------------------------------------------------------
// Converts one 8-bit RGB pixel per beat into BT.601 Y, Cb and Cr with 16.16
// fixed-point coefficients. The unit takes one pixel every clock while
// pix_stall_o is low, and passes each pixel through six register stages:
// weighted products, luma sum, luma rescale, colour difference, chroma
// multiply, and the output register. Every stage holds its own valid bit, so
// a stall on the output only backs up as far as the first empty stage, and
// bubbles are squeezed out. Register 0 (byte address 0), full_range_mode,
// selects studio range 16-235 when 0 (reset) and full range when 1; each pixel
// picks up the mode at entry. Results wrap to their low 8 bits with no
// saturation. Write the mode only while the pipeline is empty.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_pixel_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Pixel input
  input  logic                 pix_valid_i,
  output logic                 pix_stall_o,
  input  r2y_pkg::pixel_in_t   pix_i,
  // YCbCr output
  output logic                 ycc_valid_o,
  input  logic                 ycc_stall_i,
  output r2y_pkg::pixel_out_t  ycc_o
);

  logic                full_range_q, full_range_d;
  logic                reg_hit;
  logic                luma_valid, luma_stall;
  r2y_pkg::luma_beat_t luma_beat;
  logic                diff_valid, diff_stall;
  r2y_pkg::diff_beat_t diff_beat;

  // Register index is the word address; only index 0 exists.
  assign reg_hit = (32'(paddr[2]) == r2y_pkg::RegFullRangeMode);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'h0, full_range_q} : 32'h0;

  always_comb begin
    full_range_d = full_range_q;
    if (psel && penable && pwrite && reg_hit) begin
      full_range_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_range_q <= 1'b0;
    end else begin
      full_range_q <= full_range_d;
    end
  end

  // Stages 1-2: luma
  r2y_luma u_luma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (pix_valid_i),
    .stall_o      (pix_stall_o),
    .pix_i        (pix_i),
    .full_range_i (full_range_q),
    .valid_o      (luma_valid),
    .stall_i      (luma_stall),
    .beat_o       (luma_beat)
  );

  // Stages 3-4: colour differences
  r2y_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (luma_valid),
    .stall_o (luma_stall),
    .beat_i  (luma_beat),
    .valid_o (diff_valid),
    .stall_i (diff_stall),
    .beat_o  (diff_beat)
  );

  // Stages 5-6: chroma scale and output register
  r2y_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .stall_o (diff_stall),
    .beat_i  (diff_beat),
    .valid_o (ycc_valid_o),
    .stall_i (ycc_stall_i),
    .pix_o   (ycc_o)
  );

endmodule
